/* hw/rtl/omlr_pkg.sv */
// shared types and constants for the eight-octant midpoint line rasterizer
package omlr_pkg;

   localparam int COORD_BITS = 12;
   // zone-0 positions need one more bit so a negated most-negative code still fits
   localparam int POS_BITS   = COORD_BITS + 1;
   localparam int INC_BITS   = COORD_BITS + 3;
   localparam int DEC_BITS   = COORD_BITS + 4;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ZONE_0 = 3'd0,
      ZONE_1 = 3'd1,
      ZONE_2 = 3'd2,
      ZONE_3 = 3'd3,
      ZONE_4 = 3'd4,
      ZONE_5 = 3'd5,
      ZONE_6 = 3'd6,
      ZONE_7 = 3'd7
   } zone_type;

   typedef struct packed {
      op_type                        opcode;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      zone_type                      octant_zone;
      logic                          last_pixel;
   } rsp_payload_type;

   // walker state, kept in zone-0 coordinates
   typedef struct packed {
      logic signed [POS_BITS-1:0]    major_pos;
      logic signed [POS_BITS-1:0]    minor_pos;
      logic signed [POS_BITS-1:0]    major_end;
      logic signed [DEC_BITS-1:0]    decision;
      logic signed [INC_BITS-1:0]    east_increment;
      logic signed [INC_BITS-1:0]    diagonal_increment;
      zone_type                      zone;
   } line_state_type;

endpackage

/* hw/rtl/omlr_setup.sv */
// line setup: zone classification, mapping into zone 0 and initial decision terms
module omlr_setup
   import omlr_pkg::*;
(
   input  req_payload_type  req_data,
   output line_state_type   setup_state
);

   typedef struct packed {
      logic signed [POS_BITS-1:0] a;
      logic signed [POS_BITS-1:0] b;
   } point_type;

   function automatic point_type to_zone0(zone_type z, logic signed [POS_BITS-1:0] x,
                                          logic signed [POS_BITS-1:0] y);
      point_type p;
      unique case (z)
         ZONE_0: begin p.a = x;  p.b = y;  end
         ZONE_1: begin p.a = y;  p.b = x;  end
         ZONE_2: begin p.a = y;  p.b = -x; end
         ZONE_3: begin p.a = -x; p.b = y;  end
         ZONE_4: begin p.a = -x; p.b = -y; end
         ZONE_5: begin p.a = -y; p.b = -x; end
         ZONE_6: begin p.a = -y; p.b = x;  end
         ZONE_7: begin p.a = x;  p.b = -y; end
         default: begin p.a = x; p.b = y;  end
      endcase
      return p;
   endfunction

   logic signed [POS_BITS-1:0] x0, y0, x1, y1;
   logic signed [POS_BITS-1:0] dx, dy;
   logic        [POS_BITS-1:0] abs_dx, abs_dy;
   logic        [POS_BITS-1:0] d_major, d_minor;
   logic                       shallow;
   zone_type                   zone;
   point_type                  p0, p1;

   always_comb begin
      x0 = {req_data.start_x[COORD_BITS-1], req_data.start_x};
      y0 = {req_data.start_y[COORD_BITS-1], req_data.start_y};
      x1 = {req_data.end_x[COORD_BITS-1], req_data.end_x};
      y1 = {req_data.end_y[COORD_BITS-1], req_data.end_y};
      dx = x1 - x0;
      dy = y1 - y0;
      abs_dx  = dx[POS_BITS-1] ? -dx : dx;
      abs_dy  = dy[POS_BITS-1] ? -dy : dy;
      shallow = abs_dx >= abs_dy;

      case ({dx[POS_BITS-1], dy[POS_BITS-1]})
         2'b00:   zone = shallow ? ZONE_0 : ZONE_1;
         2'b10:   zone = shallow ? ZONE_3 : ZONE_2;
         2'b11:   zone = shallow ? ZONE_4 : ZONE_5;
         default: zone = shallow ? ZONE_7 : ZONE_6;
      endcase

      // in zone 0 the deltas are just the absolute deltas of major and minor axis
      d_major = shallow ? abs_dx : abs_dy;
      d_minor = shallow ? abs_dy : abs_dx;

      p0 = to_zone0(zone, x0, y0);
      p1 = to_zone0(zone, x1, y1);

      setup_state.major_pos          = p0.a;
      setup_state.minor_pos          = p0.b;
      setup_state.major_end          = p1.a;
      setup_state.decision           = (DEC_BITS'(d_minor) << 1) - DEC_BITS'(d_major);
      setup_state.east_increment     = INC_BITS'(d_minor) << 1;
      setup_state.diagonal_increment = (INC_BITS'(d_minor) << 1) - (INC_BITS'(d_major) << 1);
      setup_state.zone               = zone;
   end

endmodule

/* hw/rtl/omlr_map.sv */
// maps a zone-0 position back to screen coordinates and builds the result item
module omlr_map
   import omlr_pkg::*;
(
   input  line_state_type   line_state,
   input  logic             last_pixel,
   output rsp_payload_type  rsp_data
);

   logic signed [POS_BITS-1:0] a, b, x, y;

   always_comb begin
      a = line_state.major_pos;
      b = line_state.minor_pos;
      unique case (line_state.zone)
         ZONE_0: begin x = a;  y = b;  end
         ZONE_1: begin x = b;  y = a;  end
         ZONE_2: begin x = -b; y = a;  end
         ZONE_3: begin x = -a; y = b;  end
         ZONE_4: begin x = -a; y = -b; end
         ZONE_5: begin x = -b; y = -a; end
         ZONE_6: begin x = b;  y = -a; end
         ZONE_7: begin x = a;  y = -b; end
         default: begin x = a; y = b;  end
      endcase
      rsp_data.pixel_x     = x[COORD_BITS-1:0];
      rsp_data.pixel_y     = y[COORD_BITS-1:0];
      rsp_data.octant_zone = line_state.zone;
      rsp_data.last_pixel  = last_pixel;
   end

endmodule

/* hw/rtl/octant_midpoint_line_rasterizer_core.sv */
// top level of the eight-octant midpoint line rasterizer
//
// Requests arrive on the req_ channel (valid/ready). A start request carries both
// endpoints and always produces the first pixel of the line; a next request
// produces the following pixel, or nothing when no line is in progress. Pixels
// leave on the rsp_ channel (valid/ready), the final one of a line with
// last_pixel set. A start while a line is in progress drops the old line.
//
// A request lands in the input register, then the setup or step adder and the zone
// back-mapping feed the result register. Throughput is one request per cycle while
// the receiver takes each result, since each step is a single add and compare on
// registered walker state.
//
// A stalled receiver holds the result register; the input register then fills
// and req_ready drops until the result is taken. Reset (synchronous, active high)
// empties both registers and clears the walker state, leaving no line active.
module octant_midpoint_line_rasterizer_core
   import omlr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_data
);

   logic             in_valid_ff;
   req_payload_type  in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             line_active_ff, line_active_in;
   line_state_type   line_state_ff, line_state_in;

   line_state_type   setup_state, step_state;
   logic             advance, is_start, produce, last_pixel;

   omlr_setup u_setup (
      .req_data    (in_data_ff),
      .setup_state (setup_state)
   );

   always_comb begin
      advance  = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      is_start = in_data_ff.opcode == OP_START;
      produce  = is_start || line_active_ff;

      step_state = line_state_ff;
      step_state.major_pos = line_state_ff.major_pos + POS_BITS'(1);
      // midpoint test: negative decision stays on the minor row
      if (line_state_ff.decision[DEC_BITS-1]) begin
         step_state.decision = line_state_ff.decision
                             + DEC_BITS'(line_state_ff.east_increment);
      end else begin
         step_state.minor_pos = line_state_ff.minor_pos + POS_BITS'(1);
         step_state.decision  = line_state_ff.decision
                              + DEC_BITS'(line_state_ff.diagonal_increment);
      end

      line_state_in = is_start ? setup_state : step_state;
      last_pixel    = line_state_in.major_pos >= line_state_in.major_end;
   end

   omlr_map u_map (
      .line_state (line_state_in),
      .last_pixel (last_pixel),
      .rsp_data   (rsp_data_in)
   );

   always_comb begin
      req_ready      = !in_valid_ff || advance;
      line_active_in = line_active_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = produce;
         if (produce) begin
            line_active_in = !last_pixel;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         line_active_ff <= 1'b0;
         line_state_ff  <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff   <= rsp_valid_in;
         line_active_ff <= line_active_in;
         if (advance && produce) begin
            line_state_ff <= line_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a held input item stays put until it moves on
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register changed while stalled");

   // a next request with no line in progress yields no transfer
   assert property (@(posedge clock) disable iff (reset)
      advance && !is_start && !line_active_ff |=> !rsp_valid_ff)
      else $error("result produced for next request while idle");

   // every step moves exactly one unit along the major axis
   assert property (@(posedge clock) disable iff (reset)
      advance && !is_start && line_active_ff
      |=> line_state_ff.major_pos == $past(line_state_ff.major_pos) + POS_BITS'(1))
      else $error("major axis did not advance by one");

   // the last pixel of a line ends it
   assert property (@(posedge clock) disable iff (reset)
      advance && produce && last_pixel |=> !line_active_ff)
      else $error("line still active after last pixel");

endmodule
